// ===== src/u8sd_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the UTF-8 stream decoder and its result
// queue.
// ---------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CP_W       = 21;
    localparam int NARROW_W   = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Lead byte classification bits and payload masks.
    localparam logic [7:0] LEAD_MULTI_BIT = 8'h80;
    localparam logic [7:0] LEAD_THREE_BIT = 8'h20;
    localparam logic [7:0] LEAD_FOUR_BIT  = 8'h10;
    localparam logic [7:0] MASK_LEAD2     = 8'h1f;
    localparam logic [7:0] MASK_LEAD3     = 8'h0f;
    localparam logic [7:0] MASK_LEAD4     = 8'h07;
    localparam logic [7:0] MASK_CONT      = 8'h3f;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_end;
        logic            truncated;
    } result_t;

    // Push requests into the result queue; push1 is only used with push0.
    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

// ===== src/u8sd_result_fifo.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small queue that takes up to two results per cycle and hands out one
// result per cycle on a valid/ready channel.
// ---------------------------------------------------------------------------
module u8sd_result_fifo
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  u8sd_pkg::push_t                     push,
    input  u8sd_pkg::result_t                   wr_data0,
    input  u8sd_pkg::result_t                   wr_data1,
    output logic                                rd_valid,
    input  logic                                rd_ready,
    output u8sd_pkg::result_t                   rd_data,
    output logic [u8sd_pkg::FIFO_CW-1:0]        count
);

    u8sd_pkg::result_t                  entries [u8sd_pkg::FIFO_DEPTH];
    logic [u8sd_pkg::FIFO_AW-1:0]       wr_ptr_reg;
    logic [u8sd_pkg::FIFO_AW-1:0]       wr_ptr_next;
    logic [u8sd_pkg::FIFO_AW-1:0]       rd_ptr_reg;
    logic [u8sd_pkg::FIFO_AW-1:0]       rd_ptr_next;
    logic [u8sd_pkg::FIFO_CW-1:0]       count_reg;
    logic [u8sd_pkg::FIFO_CW-1:0]       count_next;
    logic [u8sd_pkg::FIFO_AW-1:0]       wr_ptr_plus1;
    logic                               pop;

    assign wr_ptr_plus1 = u8sd_pkg::FIFO_AW'(wr_ptr_reg + 1'b1);
    assign rd_valid     = (count_reg != '0);
    assign pop          = rd_valid && rd_ready;
    assign rd_data      = entries[rd_ptr_reg];
    assign count        = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.push0 && push.push1)
        begin
            wr_ptr_next = u8sd_pkg::FIFO_AW'(wr_ptr_reg + 2'd2);
        end
        else if (push.push0)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = pop ? u8sd_pkg::FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = u8sd_pkg::FIFO_CW'(count_reg
                      + u8sd_pkg::FIFO_CW'(push.push0)
                      + u8sd_pkg::FIFO_CW'(push.push1)
                      - u8sd_pkg::FIFO_CW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entries[wr_ptr_reg] <= wr_data0;
        end
        if (push.push0 && push.push1)
        begin
            entries[wr_ptr_plus1] <= wr_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The occupancy can never exceed the number of entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= u8sd_pkg::FIFO_CW'(u8sd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // Pointer distance agrees with the occupancy count unless full.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != u8sd_pkg::FIFO_CW'(u8sd_pkg::FIFO_DEPTH)) |->
        (u8sd_pkg::FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[u8sd_pkg::FIFO_AW-1:0]))
        else $error("result queue pointers disagree with count");

endmodule

// ===== src/utf8_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Lenient UTF-8 to code point decoder taking one byte per transaction and
// producing decoded characters plus a closing terminator per string.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-----------------------------
//  in       | input     | in_valid / in_ready  | in_byte, in_last
//  out      | output    | out_valid/ out_ready | code_point, is_end, truncated
//  cfg      | input     | cfg_valid/ cfg_ready | cfg_data (wide_char_32)
//
// Each input byte is captured in an input register and decoded from there
// by a single layer of logic, which pushes zero, one or two results into
// a four-entry result queue. One byte is taken every cycle as long as the
// queue has room for two results; a byte that produces two results (a
// character completed by the last byte, followed by its terminator) needs
// two output transfers, so with out_ready held high the sustained rate is
// one byte per cycle and one result per cycle on the output. Reset clears
// the decode state, the queue and sets wide mode. A stalled output fills
// the queue and then holds in_ready low; cfg_ready is always high.
//
module utf8_stream_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [u8sd_pkg::CP_W-1:0]   code_point,
    output logic                        is_end,
    output logic                        truncated,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    // Configuration register: 1 keeps full code points, 0 truncates to 16 bits.
    logic                               wide_reg;

    // Input register stage.
    logic                               in_vld_reg;
    logic [7:0]                         in_byte_reg;
    logic                               in_last_reg;

    // Decode state.
    logic [1:0]                         pending_reg;
    logic [1:0]                         pending_next;
    logic [u8sd_pkg::CP_W-1:0]          acc_reg;
    logic [u8sd_pkg::CP_W-1:0]          acc_next;
    logic                               disc_reg;
    logic                               disc_next;

    // Decode results.
    logic                               char_valid;
    logic [u8sd_pkg::CP_W-1:0]          char_raw;
    logic [u8sd_pkg::CP_W-1:0]          char_shaped;
    logic [u8sd_pkg::CP_W-1:0]          acc_shifted;
    u8sd_pkg::result_t                  char_res;
    u8sd_pkg::result_t                  term_res;
    u8sd_pkg::result_t                  wr_data0;
    u8sd_pkg::result_t                  wr_data1;
    u8sd_pkg::result_t                  rd_data;
    u8sd_pkg::push_t                    push;
    logic [u8sd_pkg::FIFO_CW-1:0]       fifo_count;
    logic                               fire;

    // A byte is decoded only when the queue can take both possible results.
    assign fire     = in_vld_reg &&
                      (fifo_count <= u8sd_pkg::FIFO_CW'(u8sd_pkg::FIFO_DEPTH - 2));
    assign in_ready = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wide_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // Continuation step: shift in six payload bits, dropping anything above bit 20.
    assign acc_shifted = {acc_reg[u8sd_pkg::CP_W-7:0], in_byte_reg[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        disc_next    = disc_reg;
        char_valid   = 1'b0;
        char_raw     = '0;

        if (!disc_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                acc_next     = acc_shifted;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    char_valid = 1'b1;
                    char_raw   = acc_shifted;
                    acc_next   = '0;
                end
            end
            else if (in_byte_reg == 8'h00)
            begin
                // A NUL lead byte ends the string; drop bytes until the last one.
                disc_next = 1'b1;
            end
            else if ((in_byte_reg & u8sd_pkg::LEAD_MULTI_BIT) == 8'h00)
            begin
                char_valid = 1'b1;
                char_raw   = u8sd_pkg::CP_W'(in_byte_reg);
            end
            else if ((in_byte_reg & u8sd_pkg::LEAD_THREE_BIT) == 8'h00)
            begin
                acc_next     = u8sd_pkg::CP_W'(in_byte_reg & u8sd_pkg::MASK_LEAD2);
                pending_next = 2'd1;
            end
            else if ((in_byte_reg & u8sd_pkg::LEAD_FOUR_BIT) == 8'h00)
            begin
                acc_next     = u8sd_pkg::CP_W'(in_byte_reg & u8sd_pkg::MASK_LEAD3);
                pending_next = 2'd2;
            end
            else
            begin
                // Four-byte leads, out-of-range 0xF8 and up, and stray 0xB0..0xBF.
                acc_next     = u8sd_pkg::CP_W'(in_byte_reg & u8sd_pkg::MASK_LEAD4);
                pending_next = 2'd3;
            end
        end

        // The terminator flags a sequence left open by the last byte.
        term_res.code_point = '0;
        term_res.is_end     = 1'b1;
        term_res.truncated  = (pending_next != 2'd0);

        if (in_last_reg)
        begin
            pending_next = 2'd0;
            acc_next     = '0;
            disc_next    = 1'b0;
        end
    end

    assign char_shaped = wide_reg ? char_raw
                                  : u8sd_pkg::CP_W'(char_raw[u8sd_pkg::NARROW_W-1:0]);

    always_comb
    begin
        char_res.code_point = char_shaped;
        char_res.is_end     = 1'b0;
        char_res.truncated  = 1'b0;

        // The character, when there is one, always goes ahead of the terminator.
        push.push0 = fire && (char_valid || in_last_reg);
        push.push1 = fire && char_valid && in_last_reg;
        wr_data0   = char_valid ? char_res : term_res;
        wr_data1   = term_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
            disc_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            disc_reg    <= disc_next;
        end
    end

    u8sd_result_fifo u_result_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (rd_data),
        .count    (fifo_count)
    );

    assign code_point = rd_data.code_point;
    assign is_end     = rd_data.is_end;
    assign truncated  = rd_data.truncated;

    // The terminator always carries a zero code point.
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_end) |-> (code_point == '0))
        else $error("terminator with nonzero code point");

    // Truncation is only reported on a terminator.
    a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && truncated) |-> is_end)
        else $error("truncated flag on a character result");

    // The last byte returns the decoder to its idle state.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> ((pending_reg == 2'd0) && !disc_reg && (acc_reg == '0)))
        else $error("decode state not cleared after last byte");

    // Nothing is decoded while discarding after a NUL.
    a_disc_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && disc_reg) |-> !char_valid)
        else $error("character emitted while discarding");

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives byte strings into the decoder, predicts the code points and
// terminators that each accepted byte causes, and checks every result
// transaction in order. It uses both code point widths, random idle cycles
// on both sides and one long output stall.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction before the run is declared hung. The
    // longest legal quiet stretch comes from the long output hold.
    localparam int QUIET_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 100;
    // Input register plus decode stage, with some margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 320;

    localparam u8sd_pkg::result_t NO_RESULT = '0;

    // One row of the directed table. When hand_typed is set, the expected
    // results are taken from the row itself; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              hand_typed;
        logic [1:0]        count;
        u8sd_pkg::result_t res_a;
        u8sd_pkg::result_t res_b;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [7:0]                    in_byte;
    logic                          in_last;
    logic                          out_valid;
    logic                          out_ready;
    logic [u8sd_pkg::CP_W-1:0]     code_point;
    logic                          is_end;
    logic                          truncated;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_data;

    // Shadow of the decoder: open sequence length, gathered payload, the
    // drop flag after a NUL lead, and the code point width setting.
    logic [1:0]                    pend_bytes = 2'd0;
    logic [u8sd_pkg::CP_W-1:0]     payload    = '0;
    logic                          dropping   = 1'b0;
    logic                          wide_mode  = 1'b1;

    u8sd_pkg::result_t             pending_cps[$];
    stim_row_t                     directed_rows[$];

    // The sender leaves here what the byte currently on the bus should give.
    logic                          cur_hand_typed = 1'b0;
    logic [1:0]                    cur_count      = 2'd0;
    u8sd_pkg::result_t             cur_res_a      = '0;
    u8sd_pkg::result_t             cur_res_b      = '0;

    int                  errors      = 0;
    int                  bytes_in    = 0;
    int                  cps_checked = 0;
    int                  terminators = 0;
    int                  cut_short   = 0;
    int                  mode_writes = 0;
    int                  bytes_sent  = 0;
    int                  gap_pct     = 0;
    int                  stall_pct   = 0;
    logic                hold_req    = 1'b0;

    utf8_stream_decoder uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .is_end     (is_end),
        .truncated  (truncated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Narrow mode keeps only the low 16 bits of each emitted character.
    function automatic logic [u8sd_pkg::CP_W-1:0] fit_width(
        input logic [u8sd_pkg::CP_W-1:0] cp);
        logic [u8sd_pkg::CP_W-1:0] narrow;
        narrow = cp;
        narrow[u8sd_pkg::CP_W-1:u8sd_pkg::NARROW_W] = '0;
        return wide_mode ? cp : narrow;
    endfunction

    function automatic u8sd_pkg::result_t char_result(input logic [u8sd_pkg::CP_W-1:0] cp);
        u8sd_pkg::result_t r;
        r.code_point = cp;
        r.is_end     = 1'b0;
        r.truncated  = 1'b0;
        return r;
    endfunction

    function automatic u8sd_pkg::result_t end_result(input logic cut);
        u8sd_pkg::result_t r;
        r.code_point = '0;
        r.is_end     = 1'b1;
        r.truncated  = cut;
        return r;
    endfunction

    // Advances the shadow state by one byte and returns the zero, one or two
    // results that the byte causes, in output order.
    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        output u8sd_pkg::result_t r0,
                                        output u8sd_pkg::result_t r1,
                                        output int n);
        n  = 0;
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        if (!dropping)
        begin
            if (pend_bytes != 2'd0)
            begin
                // Any byte continues an open sequence, a NUL included.
                payload    = {payload[u8sd_pkg::CP_W-7:0], b[5:0]};
                pend_bytes = pend_bytes - 2'd1;
                if (pend_bytes == 2'd0)
                begin
                    r0      = char_result(fit_width(payload));
                    n       = 1;
                    payload = '0;
                end
            end
            else if (b == 8'h00)
            begin
                dropping = 1'b1;
            end
            else if (!b[7])
            begin
                r0 = char_result(fit_width({13'd0, b}));
                n  = 1;
            end
            else if (!b[5])
            begin
                payload    = {16'd0, b[4:0]};
                pend_bytes = 2'd1;
            end
            else if (!b[4])
            begin
                payload    = {17'd0, b[3:0]};
                pend_bytes = 2'd2;
            end
            else
            begin
                // Covers 0xF0..0xFF and stray 0xB0..0xBF alike.
                payload    = {18'd0, b[2:0]};
                pend_bytes = 2'd3;
            end
        end
        if (last)
        begin
            if (n == 0)
                r0 = end_result(pend_bytes != 2'd0);
            else
                r1 = end_result(pend_bytes != 2'd0);
            n          = n + 1;
            pend_bytes = 2'd0;
            payload    = '0;
            dropping   = 1'b0;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, in one process, so
    // that a byte and a result accepted at the same edge are handled in a
    // fixed order. Each result passes the input register and the result
    // queue after its byte, so its expectation is always queued first.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        u8sd_pkg::result_t got;
        u8sd_pkg::result_t want;
        u8sd_pkg::result_t p0;
        u8sd_pkg::result_t p1;
        int                np;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                wide_mode   = cfg_data;
                mode_writes = mode_writes + 1;
            end
            if (in_valid && in_ready)
            begin
                bytes_in = bytes_in + 1;
                decode_byte(in_byte, in_last, p0, p1, np);
                if (cur_hand_typed)
                begin
                    if (cur_count > 2'd0)
                        pending_cps.push_back(cur_res_a);
                    if (cur_count > 2'd1)
                        pending_cps.push_back(cur_res_b);
                end
                else
                begin
                    if (np > 0)
                        pending_cps.push_back(p0);
                    if (np > 1)
                        pending_cps.push_back(p1);
                end
            end
            if (out_valid && out_ready)
            begin
                got.code_point = code_point;
                got.is_end     = is_end;
                got.truncated  = truncated;
                if (pending_cps.size() == 0)
                begin
                    $error("unexpected result: code_point %h is_end %b truncated %b",
                           code_point, is_end, truncated);
                    errors = errors + 1;
                end
                else
                begin
                    want        = pending_cps.pop_front();
                    cps_checked = cps_checked + 1;
                    if (want.is_end)
                        terminators = terminators + 1;
                    if (want.truncated)
                        cut_short = cut_short + 1;
                    if (got.code_point !== want.code_point)
                    begin
                        $error("code_point: expected %h, got %h",
                               want.code_point, got.code_point);
                        errors = errors + 1;
                    end
                    if (got.is_end !== want.is_end)
                    begin
                        $error("is_end: expected %b, got %b", want.is_end, got.is_end);
                        errors = errors + 1;
                    end
                    if (got.truncated !== want.truncated)
                    begin
                        $error("truncated: expected %b, got %b",
                               want.truncated, got.truncated);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: out_ready drops in random bursts. On request it holds off for
    // a long stretch so that the result queue fills and in_ready goes low
    // while the sender keeps offering bytes.
    // -----------------------------------------------------------------------
    initial
    begin : out_stall
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends a hung run: counts cycles in which no transaction of any kind
    // takes place.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $error("no transaction for %0d cycles, %0d results still expected",
               QUIET_LIMIT, pending_cps.size());
        $display("DONE: errors detected");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Sender side. Every task is entered and left at a falling edge, and at
    // each falling edge at most one assignment is made to each input.
    // -----------------------------------------------------------------------

    task automatic add_row(input logic [7:0] data, input logic last,
                           input logic hand_typed, input logic [1:0] count,
                           input u8sd_pkg::result_t res_a,
                           input u8sd_pkg::result_t res_b);
        stim_row_t row;
        row.data       = data;
        row.last       = last;
        row.hand_typed = hand_typed;
        row.count      = count;
        row.res_a      = res_a;
        row.res_b      = res_b;
        directed_rows.push_back(row);
    endtask

    // Offers one byte, possibly after a random gap, and returns at the
    // falling edge after the byte has been taken. in_valid stays high there;
    // the caller either offers the next byte or lowers it.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic hand_typed, input logic [1:0] count,
                             input u8sd_pkg::result_t res_a,
                             input u8sd_pkg::result_t res_b);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_byte        <= b;
        in_last        <= last;
        cur_hand_typed  = hand_typed;
        cur_count       = count;
        cur_res_a       = res_a;
        cur_res_b       = res_b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    // Builds one string of random characters and sends it, the final byte
    // marked last. Most characters are well formed; some bytes are noise,
    // a few are NUL, and sometimes the final character is cut short.
    task automatic send_string();
        logic [7:0]  text[$];
        logic [31:0] rnd;
        int          nchar;
        int          kind;
        int          seq_len;
        int          k;
        int          j;
        seq_len = 1;
        nchar = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        for (k = 0; k < nchar; k++)
        begin
            rnd  = $urandom;
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                text.push_back((rnd[7:0] & 8'h7f) | 8'h01);
                seq_len = 1;
            end
            else if (kind < 83)
            begin
                // Lead bytes keep bit 6 random so stray 0x80..0xBF leads occur.
                if (kind < 50)
                begin
                    text.push_back((rnd[7:0] & 8'h5f) | 8'h80);
                    seq_len = 2;
                end
                else if (kind < 68)
                begin
                    text.push_back((rnd[7:0] & 8'h4f) | 8'ha0);
                    seq_len = 3;
                end
                else
                begin
                    text.push_back((rnd[7:0] & 8'h4f) | 8'hb0);
                    seq_len = 4;
                end
                for (j = 1; j < seq_len; j++)
                begin
                    rnd = $urandom;
                    if ($urandom_range(0, 15) == 0)
                        text.push_back(rnd[7:0]);
                    else
                        text.push_back((rnd[7:0] & 8'h3f) | 8'h80);
                end
            end
            else if (kind < 97)
            begin
                text.push_back(rnd[7:0]);
                seq_len = 1;
            end
            else
            begin
                text.push_back(8'h00);
                seq_len = 1;
            end
        end
        if (seq_len > 1 && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, seq_len - 1))
                void'(text.pop_back());
        end
        for (k = 0; k < text.size(); k++)
            send_byte(text[k], k == text.size() - 1, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    endtask

    // Writes the width setting once the block has gone quiet: every result
    // has arrived and any byte that gives none has left the decode stage.
    task automatic write_wide(input logic value);
        in_valid <= 1'b0;
        while (pending_cps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        int k;
        int p;
        int phase_start;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;

        // Directed table, run with the width left at its reset value so the
        // full 21-bit extreme also checks that reset selects wide mode.
        add_row(8'h41, 1'b0, 1'b1, 2'd1, char_result(21'h000041), NO_RESULT);
        add_row(8'h7f, 1'b0, 1'b1, 2'd1, char_result(21'h00007f), NO_RESULT);
        add_row(8'h01, 1'b0, 1'b1, 2'd1, char_result(21'h000001), NO_RESULT);
        // Two-, three- and four-byte characters in their usual form.
        add_row(8'hc3, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'ha9, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'he2, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h82, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hac, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hf0, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h9f, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h98, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h80, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        // An oversized 0xFF lead followed by all-ones payload: the largest
        // code point the block can produce.
        add_row(8'hff, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hff, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hff, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hff, 1'b0, 1'b1, 2'd1, char_result(21'h1fffff), NO_RESULT);
        // A stray continuation byte as lead, then a NUL inside the sequence,
        // which only adds zero payload.
        add_row(8'h80, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h00, 1'b0, 1'b1, 2'd1, char_result(21'h000000), NO_RESULT);
        // Stray 0xA0 opens a three-byte sequence that last cuts short.
        add_row(8'ha0, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h80, 1'b1, 1'b1, 2'd1, end_result(1'b1), NO_RESULT);
        // Last byte completes a character: character, then terminator.
        add_row(8'hc2, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hbf, 1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
        // NUL lead: the rest is dropped, only a clean terminator follows.
        add_row(8'h00, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'h41, 1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
        add_row(8'hff, 1'b1, 1'b1, 2'd1, end_result(1'b0), NO_RESULT);
        // A NUL that is also the last byte.
        add_row(8'h00, 1'b1, 1'b1, 2'd1, end_result(1'b0), NO_RESULT);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        for (k = 0; k < directed_rows.size(); k++)
            send_byte(directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].hand_typed, directed_rows[k].count,
                      directed_rows[k].res_a, directed_rows[k].res_b);

        // Random strings, alternating narrow and wide mode per phase. The
        // third phase asks for the long output hold with an eager sender;
        // the last phase runs with no idling on either side.
        for (p = 0; p < PHASES; p++)
        begin
            write_wide(p % 2 == 1);
            if (p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (p == 2)
            begin
                gap_pct   = 5;
                stall_pct = 10;
                hold_req  = 1'b1;
            end
            else
            begin
                gap_pct   = $urandom_range(0, 40);
                stall_pct = $urandom_range(0, 40);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_string();
        end

        in_valid <= 1'b0;
        while (pending_cps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes, %0d results (%0d terminators, %0d cut short),",
                 bytes_in, cps_checked, terminators, cut_short);
        $display("  %0d width writes in both modes, random idling and one long output hold.",
                 mode_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== utf8_stream_decoder.f =====
src/u8sd_pkg.sv
src/u8sd_result_fifo.sv
src/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
